// ===== rtl/core/alx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Assembly lexer package
// Token codes, character constants, the token and run records, and the
// small character-class helpers shared by the lexer modules.
// ----------------------------------------------------------------------------
package alx_pkg;

	localparam int OFFSET_BITS_DEFAULT = 16;
	localparam int ROW_BITS_DEFAULT    = 16;
	localparam int FIELD_BITS          = 16;

	// Token kinds.
	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_NEWLINE = 5'd1;
	localparam logic [4:0] KIND_REG     = 5'd2;
	localparam logic [4:0] KIND_LPAREN  = 5'd3;
	localparam logic [4:0] KIND_RPAREN  = 5'd4;
	localparam logic [4:0] KIND_LBRACK  = 5'd5;
	localparam logic [4:0] KIND_RBRACK  = 5'd6;
	localparam logic [4:0] KIND_LBRACE  = 5'd7;
	localparam logic [4:0] KIND_RBRACE  = 5'd8;
	localparam logic [4:0] KIND_ARROW   = 5'd9;
	localparam logic [4:0] KIND_EQ      = 5'd10;
	localparam logic [4:0] KIND_COMMA   = 5'd11;
	localparam logic [4:0] KIND_ID      = 5'd12;
	localparam logic [4:0] KIND_FUNC    = 5'd13;
	localparam logic [4:0] KIND_DATA    = 5'd14;
	localparam logic [4:0] KIND_LABEL   = 5'd15;
	localparam logic [4:0] KIND_STR     = 5'd16;
	localparam logic [4:0] KIND_NUM     = 5'd17;
	localparam logic [4:0] KIND_ERROR   = 5'd18;

	// Number bases.
	localparam logic [1:0] BASE_BIN = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_DEC = 2'd2;
	localparam logic [1:0] BASE_HEX = 2'd3;

	// Keywords, packed as their four ASCII bytes.
	localparam logic [31:0] KW_FUNC = 32'h6675_6E63;
	localparam logic [31:0] KW_DATA = 32'h6461_7461;

	// Characters.
	localparam logic [7:0] CH_END    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [4:0]            kind;
		logic [1:0]            base;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] length;
		logic [FIELD_BITS-1:0] row;
	} token_t;

	// All tokens caused by one text byte: up to two, in order.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} run_t;

	function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [31:0] v);
		return (|v[31:FIELD_BITS]) ? {FIELD_BITS{1'b1}} : v[FIELD_BITS-1:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= CH_LC_A) && (b <= CH_LC_Z)) || ((b >= CH_UC_A) && (b <= CH_UC_Z));
	endfunction

	function automatic logic is_idchar(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_USCORE) || (b == CH_DOT);
	endfunction

	function automatic logic in_base(input logic [7:0] b, input logic [1:0] base);
		logic r;
		case (base)
			BASE_BIN: r = (b >= CH_ZERO) && (b <= CH_ONE);
			BASE_OCT: r = (b >= CH_ZERO) && (b <= CH_SEVEN);
			BASE_DEC: r = is_digit(b);
			default:  r = is_digit(b) || ((b >= CH_UC_A) && (b <= CH_UC_F))
				|| ((b >= CH_LC_A) && (b <= CH_LC_F));
		endcase
		return r;
	endfunction

endpackage : alx_pkg
`default_nettype wire

// ===== rtl/core/alx_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lexer scan unit
// Holds the scan state and, for each text byte it is told to take, builds
// the run of tokens that byte completes and moves the state on.
// ----------------------------------------------------------------------------
module alx_scan
	import alx_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
	parameter int ROW_BITS    = ROW_BITS_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] text_byte,
	output run_t            run
);

	typedef enum logic [3:0] {
		MODE_IDLE, MODE_MINUS, MODE_COMMENT, MODE_REGOPEN, MODE_ZERO,
		MODE_DIGITS, MODE_IDENT, MODE_LABEL, MODE_STRING
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_d;
	logic [ROW_BITS-1:0]    line_number_q, line_number_d;
	logic [OFFSET_BITS-1:0] start_offset_q, start_offset_d;
	logic [ROW_BITS-1:0]    start_line_q, start_line_d;
	logic [31:0]            id_prefix_q, id_prefix_d;
	logic [1:0]             digit_base_q, digit_base_d;
	logic                   escape_q, escape_d;
	logic                   reg_flag_q, reg_flag_d;
	logic [FIELD_BITS-1:0]  tok_len_q, tok_len_d;

	logic [OFFSET_BITS-1:0] off_inc;
	logic [ROW_BITS-1:0]    line_inc;
	logic [FIELD_BITS-1:0]  len_inc;
	logic [FIELD_BITS-1:0]  cur_start, cur_row, here_start, here_row;

	// Effects of scanning the byte from the idle state.
	mode_t                  i_mode;
	logic                   i_begin, i_emit, i_reg_wr, i_reg_val, i_esc_clr;
	logic                   i_pre_wr, i_base_wr;
	logic [OFFSET_BITS-1:0] i_start;
	logic [FIELD_BITS-1:0]  i_len;
	token_t                 i_tok;

	// Token ending the pending one, and whether the byte is then rescanned.
	logic                   c_emit, use_idle;
	token_t                 c_tok;

	assign off_inc   = (&byte_offset_q) ? byte_offset_q : byte_offset_q + 1'b1;
	assign line_inc  = (&line_number_q) ? line_number_q : line_number_q + 1'b1;
	assign len_inc   = (&tok_len_q) ? tok_len_q : tok_len_q + 1'b1;
	assign cur_start  = clamp_field(32'(start_offset_q));
	assign cur_row    = clamp_field(32'(start_line_q));
	assign here_start = clamp_field(32'(byte_offset_q));
	assign here_row   = clamp_field(32'(line_number_q));

	always_comb begin
		i_mode    = MODE_IDLE;
		i_begin   = 1'b0;
		i_start   = byte_offset_q;
		i_len     = FIELD_BITS'(1);
		i_emit    = 1'b0;
		i_reg_wr  = 1'b0;
		i_reg_val = 1'b0;
		i_esc_clr = 1'b0;
		i_pre_wr  = 1'b0;
		i_base_wr = 1'b0;
		i_tok     = '{kind: KIND_ERROR, base: BASE_BIN, start: here_start,
			length: FIELD_BITS'(1), row: here_row};
		case (text_byte)
			CH_END: begin
				i_emit = 1'b1;
				i_tok.kind = KIND_EOF;
				i_tok.length = '0;
			end
			CH_SPACE, CH_TAB: ;
			CH_LF: begin
				i_emit = 1'b1;
				i_tok.kind = KIND_NEWLINE;
			end
			CH_LPAREN: begin i_emit = 1'b1; i_tok.kind = KIND_LPAREN; end
			CH_RPAREN: begin i_emit = 1'b1; i_tok.kind = KIND_RPAREN; end
			CH_LBRACK: begin i_emit = 1'b1; i_tok.kind = KIND_LBRACK; end
			CH_RBRACK: begin i_emit = 1'b1; i_tok.kind = KIND_RBRACK; end
			CH_LBRACE: begin i_emit = 1'b1; i_tok.kind = KIND_LBRACE; end
			CH_RBRACE: begin i_emit = 1'b1; i_tok.kind = KIND_RBRACE; end
			CH_EQ:     begin i_emit = 1'b1; i_tok.kind = KIND_EQ; end
			CH_COMMA:  begin i_emit = 1'b1; i_tok.kind = KIND_COMMA; end
			CH_PCT: begin
				// Register text starts after the percent sign.
				i_reg_wr  = 1'b1;
				i_reg_val = 1'b1;
				i_begin   = 1'b1;
				i_mode    = MODE_REGOPEN;
				i_start   = off_inc;
				i_len     = '0;
			end
			CH_MINUS: begin
				i_begin = 1'b1;
				i_mode  = MODE_MINUS;
			end
			CH_QUOTE: begin
				i_esc_clr = 1'b1;
				i_begin   = 1'b1;
				i_mode    = MODE_STRING;
				i_start   = off_inc;
				i_len     = '0;
			end
			CH_DOT: begin
				i_begin = 1'b1;
				i_mode  = MODE_LABEL;
			end
			default: begin
				if (is_alpha(text_byte) || (text_byte == CH_USCORE)) begin
					i_begin  = 1'b1;
					i_mode   = MODE_IDENT;
					i_pre_wr = 1'b1;
				end else if (is_digit(text_byte)) begin
					i_reg_wr = 1'b1;
					i_begin  = 1'b1;
					if (text_byte == CH_ZERO) begin
						i_mode = MODE_ZERO;
					end else begin
						i_mode    = MODE_DIGITS;
						i_base_wr = 1'b1;
					end
				end else begin
					i_emit = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		mode_d         = mode_q;
		start_offset_d = start_offset_q;
		start_line_d   = start_line_q;
		id_prefix_d    = id_prefix_q;
		digit_base_d   = digit_base_q;
		escape_d       = escape_q;
		reg_flag_d     = reg_flag_q;
		tok_len_d      = tok_len_q;
		c_emit         = 1'b0;
		use_idle       = 1'b0;
		c_tok          = '{kind: KIND_ERROR, base: BASE_BIN, start: cur_start,
			length: tok_len_q, row: cur_row};

		case (mode_q)
			MODE_MINUS: begin
				mode_d = MODE_IDLE;
				c_emit = 1'b1;
				c_tok.length = FIELD_BITS'(2);
				if (text_byte == CH_MINUS) begin
					mode_d = MODE_COMMENT;
					c_emit = 1'b0;
				end else if (text_byte == CH_GT) begin
					c_tok.kind = KIND_ARROW;
				end else if (text_byte == CH_END) begin
					c_tok.length = FIELD_BITS'(1);
					use_idle = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (text_byte == CH_LF) begin
					mode_d = MODE_IDLE;
				end else if (text_byte == CH_END) begin
					use_idle = 1'b1;
				end
			end
			MODE_REGOPEN: begin
				if (is_digit(text_byte)) begin
					start_offset_d = byte_offset_q;
					start_line_d   = line_number_q;
					tok_len_d      = FIELD_BITS'(1);
					if (text_byte == CH_ZERO) begin
						mode_d = MODE_ZERO;
					end else begin
						mode_d       = MODE_DIGITS;
						digit_base_d = BASE_DEC;
					end
				end else begin
					// A percent sign with no digits is an empty register token.
					digit_base_d = BASE_DEC;
					c_emit       = 1'b1;
					c_tok        = '{kind: KIND_REG, base: BASE_DEC, start: here_start,
						length: '0, row: here_row};
					use_idle     = 1'b1;
				end
			end
			MODE_ZERO: begin
				mode_d = MODE_DIGITS;
				if ((text_byte == CH_LC_B) || (text_byte == CH_LC_X)) begin
					digit_base_d = (text_byte == CH_LC_B) ? BASE_BIN : BASE_HEX;
					tok_len_d    = len_inc;
				end else begin
					digit_base_d = BASE_OCT;
					if (in_base(text_byte, BASE_OCT)) begin
						tok_len_d = len_inc;
					end else begin
						c_emit     = 1'b1;
						c_tok.kind = reg_flag_q ? KIND_REG : KIND_NUM;
						c_tok.base = BASE_OCT;
						use_idle   = 1'b1;
					end
				end
			end
			MODE_DIGITS: begin
				if (in_base(text_byte, digit_base_q)) begin
					tok_len_d = len_inc;
				end else begin
					c_emit     = 1'b1;
					c_tok.kind = reg_flag_q ? KIND_REG : KIND_NUM;
					c_tok.base = digit_base_q;
					use_idle   = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (is_idchar(text_byte)) begin
					if (tok_len_q < FIELD_BITS'(4)) begin
						id_prefix_d = {id_prefix_q[23:0], text_byte};
					end
					tok_len_d = len_inc;
				end else begin
					c_emit     = 1'b1;
					c_tok.kind = KIND_ID;
					if ((tok_len_q == FIELD_BITS'(4)) && (id_prefix_q == KW_FUNC)) begin
						c_tok.kind = KIND_FUNC;
					end else if ((tok_len_q == FIELD_BITS'(4)) && (id_prefix_q == KW_DATA)) begin
						c_tok.kind = KIND_DATA;
					end
					use_idle = 1'b1;
				end
			end
			MODE_LABEL: begin
				if (is_idchar(text_byte)) begin
					tok_len_d = len_inc;
				end else if (text_byte == CH_COLON) begin
					c_emit       = 1'b1;
					c_tok.kind   = KIND_LABEL;
					c_tok.length = len_inc;
					mode_d       = MODE_IDLE;
				end else begin
					c_emit   = 1'b1;
					use_idle = 1'b1;
				end
			end
			MODE_STRING: begin
				if ((text_byte == CH_END) || (text_byte == CH_LF)) begin
					escape_d = 1'b0;
					c_emit   = 1'b1;
					use_idle = 1'b1;
				end else if (escape_q) begin
					escape_d  = 1'b0;
					tok_len_d = len_inc;
				end else if (text_byte == CH_QUOTE) begin
					c_emit     = 1'b1;
					c_tok.kind = KIND_STR;
					mode_d     = MODE_IDLE;
				end else begin
					if (text_byte == CH_BSLASH) begin
						escape_d = 1'b1;
					end
					tok_len_d = len_inc;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase

		// The byte that ended a token is scanned as a fresh one.
		if (use_idle) begin
			mode_d = i_mode;
			if (i_begin) begin
				start_offset_d = i_start;
				start_line_d   = line_number_q;
				tok_len_d      = i_len;
			end
			if (i_reg_wr) begin
				reg_flag_d = i_reg_val;
			end
			if (i_esc_clr) begin
				escape_d = 1'b0;
			end
			if (i_pre_wr) begin
				id_prefix_d = {24'd0, text_byte};
			end
			if (i_base_wr) begin
				digit_base_d = BASE_DEC;
			end
		end

		byte_offset_d = (text_byte != CH_END) ? off_inc : byte_offset_q;
		line_number_d = (text_byte == CH_LF) ? line_inc : line_number_q;
	end

	always_comb begin
		run.count  = 2'(c_emit) + 2'(use_idle & i_emit);
		run.first  = c_emit ? c_tok : i_tok;
		run.second = i_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			byte_offset_q  <= '0;
			line_number_q  <= ROW_BITS'(1);
			start_offset_q <= '0;
			start_line_q   <= ROW_BITS'(1);
			id_prefix_q    <= '0;
			digit_base_q   <= BASE_DEC;
			escape_q       <= 1'b0;
			reg_flag_q     <= 1'b0;
			tok_len_q      <= '0;
		end else if (advance) begin
			mode_q         <= mode_d;
			byte_offset_q  <= byte_offset_d;
			line_number_q  <= line_number_d;
			start_offset_q <= start_offset_d;
			start_line_q   <= start_line_d;
			id_prefix_q    <= id_prefix_d;
			digit_base_q   <= digit_base_d;
			escape_q       <= escape_d;
			reg_flag_q     <= reg_flag_d;
			tok_len_q      <= tok_len_d;
		end
	end

endmodule : alx_scan
`default_nettype wire

// ===== rtl/core/alx_run_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Token run queue
// Two-entry queue of token runs; hands the tokens out one per request, and
// marks the final token of each run.
// ----------------------------------------------------------------------------
module alx_run_fifo
	import alx_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire run_t                  run,
	output logic                       room,
	output logic                       token_valid,
	input  wire logic                  token_stall,
	output logic [4:0]                 token_kind,
	output logic [1:0]                 number_base,
	output logic [FIELD_BITS-1:0]      token_start,
	output logic [FIELD_BITS-1:0]      token_length,
	output logic [FIELD_BITS-1:0]      token_row,
	output logic                       last_of_run
);

	run_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q, sub_q;
	logic [1:0] count_q;
	run_t       head;
	token_t     tok;
	logic       pop_tok, pop_entry;

	assign head        = entry_q[rd_ptr_q];
	assign tok         = sub_q ? head.second : head.first;
	assign room        = (count_q != 2'd2);
	assign token_valid = (count_q != 2'd0);
	assign last_of_run = sub_q || (head.count != 2'd2);
	assign pop_tok     = token_valid && !token_stall;
	assign pop_entry   = pop_tok && last_of_run;

	assign token_kind   = tok.kind;
	assign number_base  = tok.base;
	assign token_start  = tok.start;
	assign token_length = tok.length;
	assign token_row    = tok.row;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			sub_q    <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_entry) begin
				rd_ptr_q <= ~rd_ptr_q;
				sub_q    <= 1'b0;
			end else if (pop_tok) begin
				sub_q <= 1'b1;
			end
			count_q <= count_q + 2'(push) - 2'(pop_entry);
		end
	end

endmodule : alx_run_fifo
`default_nettype wire

// ===== rtl/core/assembly_token_lexer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Assembly token lexer core
// Streams source text in, one byte per request, and streams tokens out with
// kind, number base, start offset, length and row.
// ----------------------------------------------------------------------------
// Each text byte is taken into an input register, scanned by a small state
// machine once the queue has room, and the one or two tokens it completes are
// written as one run into a two-entry output queue. A byte is accepted every
// cycle while the queue has room, so text flows at one byte per clock as
// long as no more than one token per byte is drawn on average; a byte that
// finishes a pending token and also forms a token of its own gives two
// tokens, which leave on two consecutive output requests, the second
// marked last_of_run. Spaces, tabs and comments give no token at all. Byte
// value zero ends the text: it closes whatever token is open and yields an
// end token, after which the lexer is idle again and later text continues
// the same offsets and rows. Offsets count from zero and rows from one; the
// internal counters are OFFSET_BITS and ROW_BITS wide and hold at their
// maximum, and every reported position and length holds at 65535. There is
// no clearing pass after reset; the block takes text at once.
// ----------------------------------------------------------------------------
module assembly_token_lexer_core
	import alx_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
	parameter int ROW_BITS    = ROW_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  text_valid,
	output logic                       text_stall,
	input  wire logic [7:0]            text_byte,
	output logic                       token_valid,
	input  wire logic                  token_stall,
	output logic [4:0]                 token_kind,
	output logic [1:0]                 number_base,
	output logic [FIELD_BITS-1:0]      token_start,
	output logic [FIELD_BITS-1:0]      token_length,
	output logic [FIELD_BITS-1:0]      token_row,
	output logic                       last_of_run
);

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       room, advance, accept;
	run_t       run;

	// The held byte is scanned whenever the queue can take its run; the
	// input register refills in the same cycle.
	assign advance    = valid_s1 && room;
	assign text_stall = valid_s1 && !room;
	assign accept     = text_valid && !text_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Scan state machine: state advances once per scanned byte.
	alx_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.ROW_BITS   (ROW_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.text_byte(byte_s1),
		.run      (run)
	);

	// Runs with no token (blanks, comment text, open tokens) are not queued.
	alx_run_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (advance && (run.count != 2'd0)),
		.run         (run),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.number_base (number_base),
		.token_start (token_start),
		.token_length(token_length),
		.token_row   (token_row),
		.last_of_run (last_of_run)
	);

endmodule : assembly_token_lexer_core
`default_nettype wire

// ===== test/assembly_token_lexer_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Assembly token lexer core testbench
// Streams text bytes into the lexer and compares every token that comes out
// against a cycle-free scanner kept inside a small scoreboard class. The run
// covers directed snippets and mostly well-formed random token sequences
// mixed with noise. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module assembly_token_lexer_core_tb;
	import alx_pkg::*;

	localparam int CYCLE_LIMIT    = 3_000_000;
	localparam int TEXT_ITEMS     = 1150;
	localparam int DRAIN_CYCLES   = 16;
	localparam int MAX_SHOWN      = 40;

	// Base field value reported for every kind other than num and reg.
	localparam logic [1:0] BASE_NONE = 2'd0;

	// Scanner states of the predictor.
	typedef enum logic [3:0] {
		SCAN_IDLE,
		SCAN_MINUS,
		SCAN_COMMENT,
		SCAN_REG,
		SCAN_ZERO,
		SCAN_DIGITS,
		SCAN_IDENT,
		SCAN_LABEL,
		SCAN_STRING
	} scan_state_t;

	// Receiver stall behaviors.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BURSTY
	} stall_mode_t;

	typedef struct {
		logic [4:0]  kind;
		logic [1:0]  base;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] row;
		logic        last;
	} tok_t;

	// The scoreboard holds its own copy of the scanner state. Every accepted
	// text request is scanned here, and the tokens it completes are queued
	// until the lexer presents them.
	class token_scoreboard;
		scan_state_t mode;
		logic [15:0] offs;
		logic [15:0] line;
		logic [15:0] tok_start;
		logic [15:0] tok_line;
		logic [15:0] tok_len;
		logic [31:0] prefix;
		logic [1:0]  base;
		bit          esc;
		bit          is_reg;
		tok_t        tokens_due[$];
		tok_t        run[$];
		int          errors;
		int          shown;
		int          checked;
		int          doubles;

		function new();
			mode      = SCAN_IDLE;
			offs      = 16'd0;
			line      = 16'd1;
			tok_start = 16'd0;
			tok_line  = 16'd1;
			tok_len   = 16'd0;
			prefix    = 32'd0;
			base      = BASE_DEC;
			esc       = 1'b0;
			is_reg    = 1'b0;
			errors    = 0;
			shown     = 0;
			checked   = 0;
			doubles   = 0;
		endfunction

		function int pending();
			return tokens_due.size();
		endfunction

		function logic [15:0] inc16(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function bit letter(logic [7:0] b);
			return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z);
		endfunction

		function bit numeral(logic [7:0] b);
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		function bit name_char(logic [7:0] b);
			return letter(b) || numeral(b) || b == CH_USCORE || b == CH_DOT;
		endfunction

		function bit fits_base(logic [7:0] b, logic [1:0] bs);
			case (bs)
				BASE_BIN: return b >= CH_ZERO && b <= CH_ONE;
				BASE_OCT: return b >= CH_ZERO && b <= CH_SEVEN;
				BASE_DEC: return numeral(b);
				default:  return numeral(b) || (b >= CH_UC_A && b <= CH_UC_F)
					|| (b >= CH_LC_A && b <= CH_LC_F);
			endcase
		endfunction

		function void push(logic [4:0] k, logic [1:0] bs, logic [15:0] st,
			logic [15:0] ln, logic [15:0] rw);
			tok_t t;
			if (run.size() >= 2) return;
			t.kind   = k;
			t.base   = bs;
			t.start  = st;
			t.length = ln;
			t.row    = rw;
			t.last   = 1'b0;
			run.push_back(t);
		endfunction

		function void open_tok(scan_state_t m, logic [15:0] st, logic [15:0] ln);
			mode      = m;
			tok_start = st;
			tok_line  = line;
			tok_len   = ln;
		endfunction

		function void close_number();
			push(is_reg ? KIND_REG : KIND_NUM, base, tok_start, tok_len, tok_line);
			mode = SCAN_IDLE;
		endfunction

		// A byte seen with no token open; gives at most one token.
		function void scan_fresh(logic [7:0] b, logic [15:0] o);
			mode = SCAN_IDLE;
			case (b)
				CH_END:           push(KIND_EOF, BASE_NONE, o, 16'd0, line);
				CH_SPACE, CH_TAB: ;
				CH_LF:            push(KIND_NEWLINE, BASE_NONE, o, 16'd1, line);
				CH_LPAREN:        push(KIND_LPAREN, BASE_NONE, o, 16'd1, line);
				CH_RPAREN:        push(KIND_RPAREN, BASE_NONE, o, 16'd1, line);
				CH_LBRACK:        push(KIND_LBRACK, BASE_NONE, o, 16'd1, line);
				CH_RBRACK:        push(KIND_RBRACK, BASE_NONE, o, 16'd1, line);
				CH_LBRACE:        push(KIND_LBRACE, BASE_NONE, o, 16'd1, line);
				CH_RBRACE:        push(KIND_RBRACE, BASE_NONE, o, 16'd1, line);
				CH_EQ:            push(KIND_EQ, BASE_NONE, o, 16'd1, line);
				CH_COMMA:         push(KIND_COMMA, BASE_NONE, o, 16'd1, line);
				CH_PCT: begin
					is_reg = 1'b1;
					open_tok(SCAN_REG, inc16(o), 16'd0);
				end
				CH_MINUS:         open_tok(SCAN_MINUS, o, 16'd1);
				CH_QUOTE: begin
					esc = 1'b0;
					open_tok(SCAN_STRING, inc16(o), 16'd0);
				end
				CH_DOT:           open_tok(SCAN_LABEL, o, 16'd1);
				default: begin
					if (letter(b) || b == CH_USCORE) begin
						open_tok(SCAN_IDENT, o, 16'd1);
						prefix = {24'd0, b};
					end else if (numeral(b)) begin
						is_reg = 1'b0;
						if (b == CH_ZERO) begin
							open_tok(SCAN_ZERO, o, 16'd1);
						end else begin
							base = BASE_DEC;
							open_tok(SCAN_DIGITS, o, 16'd1);
						end
					end else begin
						push(KIND_ERROR, BASE_NONE, o, 16'd1, line);
					end
				end
			endcase
		endfunction

		function void scan_digit(logic [7:0] b, logic [15:0] o);
			if (fits_base(b, base)) begin
				tok_len = inc16(tok_len);
			end else begin
				close_number();
				scan_fresh(b, o);
			end
		endfunction

		// Scans one accepted text byte and queues the tokens it completes.
		function void scan_byte(logic [7:0] b);
			logic [15:0] o;
			logic [4:0]  kind;
			o = offs;
			run.delete();
			case (mode)
				SCAN_MINUS: begin
					mode = SCAN_IDLE;
					if (b == CH_MINUS) begin
						mode = SCAN_COMMENT;
					end else if (b == CH_GT) begin
						push(KIND_ARROW, BASE_NONE, tok_start, 16'd2, tok_line);
					end else if (b == CH_END) begin
						push(KIND_ERROR, BASE_NONE, tok_start, 16'd1, tok_line);
						push(KIND_EOF, BASE_NONE, o, 16'd0, line);
					end else begin
						push(KIND_ERROR, BASE_NONE, tok_start, 16'd2, tok_line);
					end
				end
				SCAN_COMMENT: begin
					if (b == CH_LF) mode = SCAN_IDLE;
					else if (b == CH_END) scan_fresh(b, o);
				end
				SCAN_REG: begin
					if (b == CH_ZERO) begin
						open_tok(SCAN_ZERO, o, 16'd1);
					end else if (numeral(b)) begin
						base = BASE_DEC;
						open_tok(SCAN_DIGITS, o, 16'd1);
					end else begin
						base = BASE_DEC;
						push(KIND_REG, BASE_DEC, o, 16'd0, line);
						scan_fresh(b, o);
					end
				end
				SCAN_ZERO: begin
					if (b == CH_LC_B || b == CH_LC_X) begin
						base    = (b == CH_LC_B) ? BASE_BIN : BASE_HEX;
						tok_len = inc16(tok_len);
						mode    = SCAN_DIGITS;
					end else begin
						base = BASE_OCT;
						mode = SCAN_DIGITS;
						scan_digit(b, o);
					end
				end
				SCAN_DIGITS: scan_digit(b, o);
				SCAN_IDENT: begin
					if (name_char(b)) begin
						if (tok_len < 16'd4) prefix = {prefix[23:0], b};
						tok_len = inc16(tok_len);
					end else begin
						kind = KIND_ID;
						if (tok_len == 16'd4 && prefix == KW_FUNC) kind = KIND_FUNC;
						else if (tok_len == 16'd4 && prefix == KW_DATA) kind = KIND_DATA;
						push(kind, BASE_NONE, tok_start, tok_len, tok_line);
						scan_fresh(b, o);
					end
				end
				SCAN_LABEL: begin
					if (name_char(b)) begin
						tok_len = inc16(tok_len);
					end else if (b == CH_COLON) begin
						push(KIND_LABEL, BASE_NONE, tok_start, inc16(tok_len), tok_line);
						mode = SCAN_IDLE;
					end else begin
						push(KIND_ERROR, BASE_NONE, tok_start, tok_len, tok_line);
						scan_fresh(b, o);
					end
				end
				SCAN_STRING: begin
					if (b == CH_END || b == CH_LF) begin
						esc = 1'b0;
						push(KIND_ERROR, BASE_NONE, tok_start, tok_len, tok_line);
						scan_fresh(b, o);
					end else if (esc) begin
						esc     = 1'b0;
						tok_len = inc16(tok_len);
					end else if (b == CH_QUOTE) begin
						push(KIND_STR, BASE_NONE, tok_start, tok_len, tok_line);
						mode = SCAN_IDLE;
					end else begin
						if (b == CH_BSLASH) esc = 1'b1;
						tok_len = inc16(tok_len);
					end
				end
				default: scan_fresh(b, o);
			endcase
			if (b != CH_END) offs = inc16(offs);
			if (b == CH_LF) line = inc16(line);
			if (run.size() > 0) run[run.size() - 1].last = 1'b1;
			if (run.size() == 2) doubles++;
			foreach (run[i]) tokens_due.push_back(run[i]);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("%0t: token %0d %s expected %0d actual %0d",
						$time, checked, field, want, got);
				end
			end
		endfunction

		// Compares one accepted token with the oldest one still due.
		function void match_token(logic [4:0] k, logic [1:0] bs, logic [15:0] st,
			logic [15:0] ln, logic [15:0] rw, logic lst);
			tok_t t;
			if (tokens_due.size() == 0) begin
				errors++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("%0t: unexpected token expected none actual kind %0d start %0d",
						$time, k, st);
				end
				return;
			end
			t = tokens_due.pop_front();
			compare("kind", t.kind, k);
			compare("base", t.base, bs);
			compare("start", t.start, st);
			compare("length", t.length, ln);
			compare("row", t.row, rw);
			compare("last_of_run", t.last, lst);
			checked++;
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        text_valid  = 1'b0;
	logic        text_stall;
	logic [7:0]  text_byte   = 8'd0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [4:0]  token_kind;
	logic [1:0]  number_base;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_row;
	logic        last_of_run;

	token_scoreboard lex = new();

	logic [7:0]  frag[$];
	bit          mid_drained  = 1'b0;
	int          burst_left   = 0;
	int          bytes_sent   = 0;
	int          random_items = 0;
	int          cycles       = 0;
	int          stall_hold   = 0;
	int          stall_tick   = 0;
	stall_mode_t stall_mode   = STALL_NONE;

	assembly_token_lexer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.number_base  (number_base),
		.token_start  (token_start),
		.token_length (token_length),
		.token_row    (token_row),
		.last_of_run  (last_of_run)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d tokens still due", $time, lex.pending());
			$display("assembly_token_lexer_core_tb: FAIL");
			$finish;
		end
	end

	// The receiver switches among four stall behaviors, picked at random.
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 150 == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		end
		if (stall_hold > 0) begin
			stall_hold--;
			token_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  token_stall <= 1'b0;
				STALL_LIGHT: token_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: token_stall <= ($urandom_range(0, 1) == 0);
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						stall_hold  = $urandom_range(1, 12);
						token_stall <= 1'b1;
					end else begin
						token_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// Tokens are sampled at the edge where they are accepted, so the values
	// seen are the ones held before the edge.
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			lex.match_token(token_kind, number_base, token_start, token_length,
				token_row, last_of_run);
		end
	end

	// Presents one text request and holds it until accepted. After a burst of
	// random length the sender may go quiet for a while; the payload is
	// scrambled while valid is low, since it carries no meaning then.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		text_valid <= 1'b1;
		text_byte  <= b;
		@(posedge clk);
		while (text_stall) @(posedge clk);
		lex.scan_byte(b);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 15);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
				: $urandom_range(0, 4);
			if (gap > 0) begin
				text_valid <= 1'b0;
				text_byte  <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// Holds the sender off until the lexer has delivered everything it owes.
	task automatic drain();
		text_valid <= 1'b0;
		@(posedge clk);
		while (lex.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick(input string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
	endtask

	// Builds one random fragment of source text. Most fragments are
	// well-formed tokens with random content; the rest are broken forms,
	// stray bytes and end markers.
	task automatic make_fragment();
		string namech;
		string hexch;
		int    r;
		namech = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
		hexch  = "0123456789abcdefgABCDEFG";
		frag.delete();
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				frag.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
				repeat ($urandom_range(0, 6)) frag.push_back(pick(namech));
			end
			3: begin
				case ($urandom_range(0, 3))
					0: add_text("func");
					1: add_text("data");
					2: add_text("fun");
					default: add_text("datas");
				endcase
			end
			4, 5: begin
				frag.push_back(pick("123456789"));
				repeat ($urandom_range(0, 4)) frag.push_back(pick("0123456789"));
			end
			6: begin
				add_text("0b");
				repeat ($urandom_range(0, 5)) frag.push_back(pick("01012"));
			end
			7: begin
				add_text("0x");
				repeat ($urandom_range(0, 5)) frag.push_back(pick(hexch));
			end
			8: begin
				frag.push_back(CH_ZERO);
				repeat ($urandom_range(0, 4)) frag.push_back(pick("0123456789"));
			end
			9: begin
				frag.push_back(CH_PCT);
				r = $urandom_range(0, 3);
				if (r == 0) begin
					add_text("0x");
					repeat ($urandom_range(1, 3)) frag.push_back(pick(hexch));
				end else if (r == 3) begin
					frag.push_back(pick("abz_.(,"));
				end else begin
					repeat ($urandom_range(1, 3)) frag.push_back(pick("0123456789"));
				end
			end
			10: begin
				frag.push_back(CH_DOT);
				repeat ($urandom_range(0, 5)) frag.push_back(pick(namech));
				if ($urandom_range(0, 4) != 0) frag.push_back(CH_COLON);
			end
			11, 12: begin
				frag.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					r = $urandom_range(0, 19);
					if (r < 2) begin
						frag.push_back(CH_BSLASH);
						frag.push_back(8'($urandom_range(1, 255)));
					end else if (r == 2) begin
						frag.push_back(CH_LF);
					end else begin
						frag.push_back(8'($urandom_range(8'h23, 8'h7E)));
					end
				end
				if ($urandom_range(0, 7) != 0) frag.push_back(CH_QUOTE);
			end
			13, 14: frag.push_back(pick("()[]{}=,\n"));
			15: begin
				case ($urandom_range(0, 3))
					0: add_text("->");
					1: begin
						frag.push_back(CH_MINUS);
						frag.push_back(8'($urandom_range(1, 255)));
					end
					2: begin
						add_text("--");
						repeat ($urandom_range(0, 6)) frag.push_back(8'($urandom_range(1, 255)));
						frag.push_back(CH_LF);
					end
					default: add_text("-\n");
				endcase
			end
			16: frag.push_back(pick(" \t\n"));
			17: frag.push_back(8'($urandom_range(1, 255)));
			18: frag.push_back(($urandom_range(0, 2) == 0) ? CH_END : 8'($urandom_range(1, 127)));
			default: frag.push_back(8'($urandom_range(128, 255)));
		endcase
		// Half the time the next token starts right against this one, which
		// is what makes one byte close two tokens.
		if ($urandom_range(0, 1) == 0) frag.push_back(pick(" \t"));
	endtask

	task automatic send_fragment();
		foreach (frag[i]) begin
			send_byte(frag[i]);
			if (frag[i] != CH_SPACE && frag[i] != CH_TAB) random_items++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed snippets: every punctuation mark, keywords, all number
		// bases with out-of-range digits, registers with and without digits,
		// labels with and without a colon, escaped quotes, newline and end
		// inside a string, every minus form, comments, and unknown bytes.
		send_text("()[]{}=,\n");
		send_text("func data funcx dat _fu9.k\n");
		send_text("%12 %0x1F %0b101 %017 %q\n");
		send_text("0b0121 0x9aFg 0778 0x 09 123");
		send_byte(CH_END);
		send_text(".lbl_1: .nocolon\n");
		send_text("\"a\\\"b\" \"x\\\ny\n");
		send_text("\"open");
		send_byte(CH_END);
		send_text("-> -a -\n -");
		send_byte(CH_END);
		send_text("-- comment ( ) \n");
		send_text("\001\377\200~#:\n");
		send_text("\t %");
		send_byte(CH_END);
		send_text("--");
		send_byte(CH_END);
		send_text("a.b_9:");
		send_byte(CH_END);
		send_text("0");
		send_byte(CH_END);
		send_text("\"\"\n");
		drain();

		// Random token streams, with one full pause halfway through.
		while (bytes_sent < TEXT_ITEMS) begin
			make_fragment();
			send_fragment();
			if (!mid_drained && bytes_sent >= TEXT_ITEMS / 2) begin
				mid_drained = 1'b1;
				drain();
			end
		end
		send_byte(CH_END);

		text_valid <= 1'b0;
		@(posedge clk);
		while (lex.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d text bytes (%0d random), compared %0d tokens, %0d bytes closed two.",
			bytes_sent, random_items, lex.checked, lex.doubles);
		$display("Directed forms and random text ran under bursty input and mixed output stalls.");
		if (lex.errors == 0 && lex.pending() == 0) begin
			$display("assembly_token_lexer_core_tb: PASS");
		end else begin
			$display("assembly_token_lexer_core_tb: FAIL");
		end
		$finish;
	end

endmodule : assembly_token_lexer_core_tb
`default_nettype wire

// ===== sim.f =====
rtl/core/alx_pkg.sv
rtl/core/alx_scan.sv
rtl/core/alx_run_fifo.sv
rtl/core/assembly_token_lexer_core.sv
test/assembly_token_lexer_core_tb.sv
